// ===== rtl/redmean_color_distance_defines.svh =====
// assertion macros shared by the rtl files
`ifndef REDMEAN_COLOR_DISTANCE_DEFINES_SVH
`define REDMEAN_COLOR_DISTANCE_DEFINES_SVH

`ifndef SYNTHESIS

// same-cycle check
`define RCD_ASSERT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

// next-cycle check
`define RCD_ASSERT_NXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

`else

`define RCD_ASSERT(label, clk, rst, ante, cons)
`define RCD_ASSERT_NXT(label, clk, rst, ante, cons)

`endif

`endif

// ===== rtl/rcd_pkg.sv =====
package rcd_pkg;

   localparam int CHAN_W     = 8;
   localparam int SUM_W      = CHAN_W + 1;
   localparam int SQ_W       = 2 * CHAN_W;
   localparam int WT_W       = 11;
   localparam int PROD_W     = WT_W + SQ_W;
   localparam int GREEN_SH   = 11;
   localparam int X_W        = 29;
   localparam int FRAC_SH    = 9;
   localparam int Y_W        = X_W - FRAC_SH;
   localparam int DIST_W     = 10;
   localparam int ROOT_STEPS = DIST_W;
   localparam int REM_W      = DIST_W + 3;
   localparam int REQ_DATA_W = 6 * CHAN_W;
   localparam int RSP_DATA_W = 16;

   localparam logic [WT_W-1:0]   RED_BASE  = 11'd1024;
   localparam logic [WT_W-1:0]   BLUE_BASE = 11'd1534;
   localparam logic [DIST_W-1:0] DIST_MAX  = 10'd764;

   typedef struct packed {
      logic [CHAN_W-1:0] blue;
      logic [CHAN_W-1:0] green;
      logic [CHAN_W-1:0] red;
   } color_type;

endpackage

// ===== rtl/rcd_weight.sv =====
`include "redmean_color_distance_defines.svh"

module rcd_weight (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  en,
   input  logic                  in_valid,
   input  rcd_pkg::color_type    src,
   input  rcd_pkg::color_type    dst,
   output logic                  out_valid,
   output logic [rcd_pkg::X_W-1:0] out_x
);
   import rcd_pkg::*;

   // stage 1: channel differences and red sum
   logic              s1_valid_ff, s1_valid_in;
   logic [SUM_W-1:0]  s1_sum_ff, s1_sum_in;
   logic [CHAN_W-1:0] s1_dr_ff, s1_dr_in, s1_dg_ff, s1_dg_in, s1_db_ff, s1_db_in;
   // stage 2: squares
   logic              s2_valid_ff;
   logic [SUM_W-1:0]  s2_sum_ff;
   logic [SQ_W-1:0]   s2_sqr_ff, s2_sqr_in, s2_sqg_ff, s2_sqg_in, s2_sqb_ff, s2_sqb_in;
   // stage 3: weighted red and blue terms
   logic              s3_valid_ff;
   logic [SQ_W-1:0]   s3_sqg_ff;
   logic [PROD_W-1:0] s3_pr_ff, s3_pr_in, s3_pb_ff, s3_pb_in;
   logic [WT_W-1:0]   wt_red, wt_blue;
   // stage 4: weighted square sum
   logic              s4_valid_ff;
   logic [X_W-1:0]    s4_x_ff, s4_x_in;

   function automatic logic [CHAN_W-1:0] abs_diff(input logic [CHAN_W-1:0] a,
                                                  input logic [CHAN_W-1:0] b);
      abs_diff = (a >= b) ? (a - b) : (b - a);
   endfunction

   always_comb begin
      s1_valid_in = in_valid;
      s1_sum_in   = SUM_W'(src.red) + SUM_W'(dst.red);
      s1_dr_in    = abs_diff(src.red, dst.red);
      s1_dg_in    = abs_diff(src.green, dst.green);
      s1_db_in    = abs_diff(src.blue, dst.blue);

      s2_sqr_in = SQ_W'(s1_dr_ff) * SQ_W'(s1_dr_ff);
      s2_sqg_in = SQ_W'(s1_dg_ff) * SQ_W'(s1_dg_ff);
      s2_sqb_in = SQ_W'(s1_db_ff) * SQ_W'(s1_db_ff);

      wt_red   = RED_BASE + WT_W'(s2_sum_ff);
      wt_blue  = BLUE_BASE - WT_W'(s2_sum_ff);
      s3_pr_in = PROD_W'(wt_red) * PROD_W'(s2_sqr_ff);
      s3_pb_in = PROD_W'(wt_blue) * PROD_W'(s2_sqb_ff);

      s4_x_in = X_W'(s3_pr_ff) + X_W'({s3_sqg_ff, GREEN_SH'(0)}) + X_W'(s3_pb_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         s3_valid_ff <= 1'b0;
         s4_valid_ff <= 1'b0;
      end else if (en) begin
         s1_valid_ff <= s1_valid_in;
         s2_valid_ff <= s1_valid_ff;
         s3_valid_ff <= s2_valid_ff;
         s4_valid_ff <= s3_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         s1_sum_ff <= s1_sum_in;
         s1_dr_ff  <= s1_dr_in;
         s1_dg_ff  <= s1_dg_in;
         s1_db_ff  <= s1_db_in;
         s2_sum_ff <= s1_sum_ff;
         s2_sqr_ff <= s2_sqr_in;
         s2_sqg_ff <= s2_sqg_in;
         s2_sqb_ff <= s2_sqb_in;
         s3_sqg_ff <= s2_sqg_ff;
         s3_pr_ff  <= s3_pr_in;
         s3_pb_ff  <= s3_pb_in;
         s4_x_ff   <= s4_x_in;
      end
   end

   assign out_valid = s4_valid_ff;
   assign out_x     = s4_x_ff;

   // equal channels give all-zero squares in the square stage
   `RCD_ASSERT_NXT(a_zero_diff_zero_sq, clock, reset,
      en && s1_valid_ff && s1_dr_ff == '0 && s1_dg_ff == '0 && s1_db_ff == '0,
      s2_sqr_ff == '0 && s2_sqg_ff == '0 && s2_sqb_ff == '0)

endmodule

// ===== rtl/rcd_root_step.sv =====
module rcd_root_step (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     en,
   input  logic                     in_valid,
   input  logic [rcd_pkg::REM_W-1:0]  in_rem,
   input  logic [rcd_pkg::DIST_W-1:0] in_root,
   input  logic [rcd_pkg::Y_W-1:0]    in_rad,
   output logic                     out_valid,
   output logic [rcd_pkg::REM_W-1:0]  out_rem,
   output logic [rcd_pkg::DIST_W-1:0] out_root,
   output logic [rcd_pkg::Y_W-1:0]    out_rad
);
   import rcd_pkg::*;

   logic              valid_ff;
   logic [REM_W-1:0]  rem_ff, rem_in, rem_sh, trial;
   logic [DIST_W-1:0] root_ff, root_in;
   logic [Y_W-1:0]    rad_ff, rad_in;
   logic              take;

   // one root bit per step: bring down two radicand bits, try 4*root+1
   always_comb begin
      rem_sh  = {in_rem[REM_W-3:0], in_rad[Y_W-1 -: 2]};
      trial   = {1'b0, in_root, 2'b01};
      take    = (rem_sh >= trial);
      rem_in  = take ? (rem_sh - trial) : rem_sh;
      root_in = {in_root[DIST_W-2:0], take};
      rad_in  = {in_rad[Y_W-3:0], 2'b00};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (en) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         rem_ff  <= rem_in;
         root_ff <= root_in;
         rad_ff  <= rad_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_rem   = rem_ff;
   assign out_root  = root_ff;
   assign out_rad   = rad_ff;

endmodule

// ===== rtl/rcd_root.sv =====
`include "redmean_color_distance_defines.svh"

module rcd_root (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     en,
   input  logic                     in_valid,
   input  logic [rcd_pkg::Y_W-1:0]    in_rad,
   output logic                     out_valid,
   output logic [rcd_pkg::DIST_W-1:0] out_root
);
   import rcd_pkg::*;

   logic              st_valid [0:ROOT_STEPS];
   logic [REM_W-1:0]  st_rem   [0:ROOT_STEPS];
   logic [DIST_W-1:0] st_root  [0:ROOT_STEPS];
   logic [Y_W-1:0]    st_rad   [0:ROOT_STEPS];

   assign st_valid[0] = in_valid;
   assign st_rem[0]   = '0;
   assign st_root[0]  = '0;
   assign st_rad[0]   = in_rad;

   for (genvar i = 0; i < ROOT_STEPS; i++) begin : g_step
      rcd_root_step u_step (
         .clock     (clock),
         .reset     (reset),
         .en        (en),
         .in_valid  (st_valid[i]),
         .in_rem    (st_rem[i]),
         .in_root   (st_root[i]),
         .in_rad    (st_rad[i]),
         .out_valid (st_valid[i+1]),
         .out_rem   (st_rem[i+1]),
         .out_root  (st_root[i+1]),
         .out_rad   (st_rad[i+1])
      );
   end

   assign out_valid = st_valid[ROOT_STEPS];
   assign out_root  = st_root[ROOT_STEPS];

   // square root invariant: leftover never exceeds twice the root
   `RCD_ASSERT(a_rem_bound, clock, reset, out_valid,
      st_rem[ROOT_STEPS] <= REM_W'({out_root, 1'b0}))

   // an item in the last step always reaches the output when the pipe moves
   `RCD_ASSERT_NXT(a_last_step_moves, clock, reset,
      en && st_valid[ROOT_STEPS-1], out_valid)

endmodule

// ===== rtl/redmean_color_distance.sv =====
// channel | dir | fields (lsb first)                                            | bits
// req     | in  | src_red, src_green, src_blue, dst_red, dst_green, dst_blue (8 each) | 48
// rsp     | out | distance (10 bits), 6 zero pad bits                           | 16
//
// one request per cycle sustained while responses are taken; 14 register stages: 4 front-end stages
// (difference, square, weight, sum) and 10 square root stages, one root bit each
// rsp_tvalid is the valid bit of the last square root stage
// the whole pipe advances together: it moves when the output register is
// empty or taken, and req_tready follows that same enable
// synchronous active-high reset clears only the valid bits
`include "redmean_color_distance_defines.svh"

module redmean_color_distance (
   input  logic                          clock,
   input  logic                          reset,
   // src_red, src_green, src_blue, dst_red, dst_green, dst_blue
   input  logic [rcd_pkg::REQ_DATA_W-1:0] req_tdata,
   input  logic                          req_tvalid,
   output logic                          req_tready,
   // distance, zero pad
   output logic [rcd_pkg::RSP_DATA_W-1:0] rsp_tdata,
   output logic                          rsp_tvalid,
   input  logic                          rsp_tready
);
   import rcd_pkg::*;

   color_type         src, dst;
   logic              en;
   logic              acc_valid;
   logic              x_valid;
   logic [X_W-1:0]    x_sum;
   logic              root_valid;
   logic [DIST_W-1:0] distance;

   // unpack the request: three source channels, then three destination channels
   assign src.red   = req_tdata[0*CHAN_W +: CHAN_W];
   assign src.green = req_tdata[1*CHAN_W +: CHAN_W];
   assign src.blue  = req_tdata[2*CHAN_W +: CHAN_W];
   assign dst.red   = req_tdata[3*CHAN_W +: CHAN_W];
   assign dst.green = req_tdata[4*CHAN_W +: CHAN_W];
   assign dst.blue  = req_tdata[5*CHAN_W +: CHAN_W];

   // global pipe enable, output slot free or being drained
   assign en         = !root_valid || rsp_tready;
   assign req_tready = en;
   assign acc_valid  = req_tvalid;

   // weighted square sum, 512 times the squared distance
   rcd_weight u_weight (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (acc_valid),
      .src       (src),
      .dst       (dst),
      .out_valid (x_valid),
      .out_x     (x_sum)
   );

   // dropping the low 9 bits keeps the floor exact: 512*n^2 <= x iff n^2 <= x/512
   rcd_root u_root (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (x_valid),
      .in_rad    (x_sum[X_W-1:FRAC_SH]),
      .out_valid (root_valid),
      .out_root  (distance)
   );

   assign rsp_tvalid = root_valid;
   assign rsp_tdata  = {(RSP_DATA_W - DIST_W)'(0), distance};

   // largest possible redmean distance for 8-bit channels
   `RCD_ASSERT(a_dist_range, clock, reset, rsp_tvalid, distance <= DIST_MAX)

endmodule

// ===== tb/redmean_color_distance_tb.sv =====
module redmean_color_distance_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import rcd_pkg::*;

   localparam int DIST_PAD_W   = RSP_DATA_W - DIST_W;
   // no request or response for this many cycles means the block is stuck
   localparam int STALL_LIMIT  = 2000;
   // pipe is 14 deep, give it room to show any stray response
   localparam int DRAIN_CYCLES = 40;
   localparam int RANDOM_REQS  = 1500;

   // one request: first color in the low 24 bits, second color above it
   typedef struct packed {
      color_type dst;
      color_type src;
   } color_pair_type;

   // keeps the expected distances in request order and grades each response
   class distance_scoreboard;
      logic [DIST_W-1:0] expected_distances[$];
      int                mismatches;
      int                responses_checked;
      int                requests_noted;
      int                zero_distances;
      logic [DIST_W-1:0] max_distance;

      function new();
         mismatches        = 0;
         responses_checked = 0;
         requests_noted    = 0;
         zero_distances    = 0;
         max_distance      = '0;
      endfunction

      static function logic [CHAN_W-1:0] chan_gap(logic [CHAN_W-1:0] a, logic [CHAN_W-1:0] b);
         return (a >= b) ? a - b : b - a;
      endfunction

      // exact integer redmean: weighted square, then largest n with 512*n^2 <= it
      static function logic [DIST_W-1:0] redmean_distance(color_pair_type p);
         logic [SUM_W-1:0]  red_sum;
         logic [X_W-1:0]    red_term;
         logic [X_W-1:0]    green_term;
         logic [X_W-1:0]    blue_term;
         logic [X_W-1:0]    weighted_sq;
         logic [DIST_W-1:0] root;
         logic [DIST_W-1:0] trial;
         logic [39:0]       trial_sq;
         red_sum     = {1'b0, p.src.red} + {1'b0, p.dst.red};
         red_term    = X_W'(RED_BASE + red_sum) * X_W'(chan_gap(p.src.red, p.dst.red))
                       * X_W'(chan_gap(p.src.red, p.dst.red));
         green_term  = (X_W'(chan_gap(p.src.green, p.dst.green))
                       * X_W'(chan_gap(p.src.green, p.dst.green))) << GREEN_SH;
         blue_term   = X_W'(BLUE_BASE - red_sum) * X_W'(chan_gap(p.src.blue, p.dst.blue))
                       * X_W'(chan_gap(p.src.blue, p.dst.blue));
         weighted_sq = red_term + green_term + blue_term;
         root = '0;
         for (int b = DIST_W - 1; b >= 0; b--) begin
            trial    = root | (DIST_W'(1) << b);
            trial_sq = 40'(trial) * 40'(trial);
            if ((trial_sq << FRAC_SH) <= 40'(weighted_sq))
               root = trial;
         end
         return root;
      endfunction

      function void note_request(color_pair_type p);
         expected_distances.push_back(redmean_distance(p));
         requests_noted++;
      endfunction

      function void check_response(logic [RSP_DATA_W-1:0] word);
         logic [DIST_W-1:0]     got_distance;
         logic [DIST_PAD_W-1:0] got_pad;
         logic [DIST_W-1:0]     want;
         got_distance = word[DIST_W-1:0];
         got_pad      = word[RSP_DATA_W-1:DIST_W];
         if (expected_distances.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("unexpected response: distance %0d pad %0h", got_distance, got_pad);
            return;
         end
         want = expected_distances.pop_front();
         responses_checked++;
         if (want == 0) zero_distances++;
         if (want > max_distance) max_distance = want;
         if (got_distance !== want || got_pad !== '0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("response %0d: distance expected %0d got %0d, pad expected 0 got %0h",
                        responses_checked, want, got_distance, got_pad);
         end
      endfunction

      function int pending();
         return expected_distances.size();
      endfunction
   endclass

   logic                  clock;
   logic                  reset;
   logic [REQ_DATA_W-1:0] req_tdata;
   logic                  req_tvalid;
   logic                  req_tready;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic                  rsp_tvalid;
   logic                  rsp_tready;

   distance_scoreboard sb = new();
   int directed_reqs;
   int idle_cycles;

   redmean_color_distance u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tdata  (req_tdata),   // src_red, src_green, src_blue, dst_red, dst_green, dst_blue
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tdata  (rsp_tdata),   // distance, zero pad
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   // ---------------------------------------------------------------
   // request side
   // ---------------------------------------------------------------

   function automatic color_pair_type make_pair(int sr, int sg, int sb_, int dr, int dg, int db);
      color_pair_type p;
      p.src.red   = CHAN_W'(sr);
      p.src.green = CHAN_W'(sg);
      p.src.blue  = CHAN_W'(sb_);
      p.dst.red   = CHAN_W'(dr);
      p.dst.green = CHAN_W'(dg);
      p.dst.blue  = CHAN_W'(db);
      return p;
   endfunction

   // small step away from a channel value, clipped to the channel range
   function automatic logic [CHAN_W-1:0] nudge(logic [CHAN_W-1:0] c);
      int v;
      v = int'(c) + int'($urandom_range(0, 12)) - 6;
      if (v < 0) v = 0;
      if (v > 255) v = 255;
      return CHAN_W'(v);
   endfunction

   // mix of wide, close, saturated, equal and one-channel color pairs
   function automatic color_pair_type random_pair();
      color_pair_type p;
      int             kind;
      kind = $urandom_range(0, 9);
      p    = color_pair_type'(REQ_DATA_W'({$urandom, $urandom}));
      case (kind)
         5, 6: begin
            // nearby colors: small distances and root boundaries
            p.dst.red   = nudge(p.src.red);
            p.dst.green = nudge(p.src.green);
            p.dst.blue  = nudge(p.src.blue);
         end
         7: begin
            // every channel pinned to an end of its range
            p = color_pair_type'({REQ_DATA_W{1'b0}});
            for (int i = 0; i < 6; i++)
               if ($urandom_range(0, 1)) p[i*CHAN_W +: CHAN_W] = '1;
         end
         8: p.dst = p.src;
         9: begin
            // at most one channel differs
            p.dst = p.src;
            case ($urandom_range(0, 2))
               0: p.dst.red   = CHAN_W'($urandom);
               1: p.dst.green = CHAN_W'($urandom);
               default: p.dst.blue = CHAN_W'($urandom);
            endcase
         end
         default: ;
      endcase
      return p;
   endfunction

   // holds the request until it is taken, then records the expected distance
   task automatic send_request(color_pair_type p);
      @(negedge clock);
      req_tdata  <= p;
      req_tvalid <= 1'b1;
      do @(posedge clock); while (!req_tready);
      sb.note_request(p);
   endtask

   int burst_left = 0;

   // bursts of random length; some long bursts run with no gap at all
   task automatic pace_requests();
      int gap;
      if (burst_left > 0) begin
         burst_left--;
         return;
      end
      if ($urandom_range(0, 3) == 0) begin
         burst_left = $urandom_range(16, 64);
         gap        = 0;
      end else begin
         burst_left = $urandom_range(0, 15);
         gap        = $urandom_range(0, 12);
      end
      if (gap > 0) begin
         @(negedge clock);
         req_tvalid <= 1'b0;
         repeat (gap - 1) @(negedge clock);
      end
   endtask

   // ---------------------------------------------------------------
   // response side: ready pattern changes mode whenever the mode counter runs out of cycles
   // ---------------------------------------------------------------
   int ready_mode = 0;
   int mode_cycles = 0;
   int stall_left = 0;

   always @(negedge clock) begin
      if (mode_cycles == 0) begin
         ready_mode  <= $urandom_range(0, 2);
         mode_cycles <= 64;
      end else begin
         mode_cycles <= mode_cycles - 1;
      end
      if (stall_left > 0) begin
         rsp_tready <= 1'b0;
         stall_left <= stall_left - 1;
      end else begin
         case (ready_mode)
            0: rsp_tready <= 1'b1;                              // always taking
            1: rsp_tready <= 1'($urandom_range(0, 1));          // coin flip per cycle
            default: begin
               // mostly ready with the odd long stall
               if ($urandom_range(0, 15) == 0) begin
                  rsp_tready <= 1'b0;
                  stall_left <= $urandom_range(5, 40);
               end else begin
                  rsp_tready <= 1'b1;
               end
            end
         endcase
      end
   end

   // every accepted response is graded against the oldest expectation
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready)
         sb.check_response(rsp_tdata);
   end

   // watchdog: cycles in a row with neither a request nor a response taken
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= STALL_LIMIT) begin
            $display("no progress for %0d cycles, %0d responses outstanding",
                     STALL_LIMIT, sb.pending());
            $display("SCOREBOARD MISMATCH");
            $finish;
         end
      end
   end

   // ---------------------------------------------------------------
   // main sequence
   // ---------------------------------------------------------------
   initial begin
      color_pair_type directed[$];
      reset       = 1'b1;
      req_tdata   = '0;
      req_tvalid  = 1'b0;
      rsp_tready  = 1'b0;
      idle_cycles = 0;
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // identical colors give zero distance
      directed.push_back(make_pair(0, 0, 0, 0, 0, 0));
      directed.push_back(make_pair(255, 255, 255, 255, 255, 255));
      directed.push_back(make_pair(17, 200, 93, 17, 200, 93));
      // black against white both ways: the largest distance
      directed.push_back(make_pair(0, 0, 0, 255, 255, 255));
      directed.push_back(make_pair(255, 255, 255, 0, 0, 0));
      // single channel at full swing, with the red sum low and high
      directed.push_back(make_pair(255, 0, 0, 0, 0, 0));
      directed.push_back(make_pair(0, 255, 0, 0, 0, 0));
      directed.push_back(make_pair(0, 0, 255, 0, 0, 0));
      directed.push_back(make_pair(255, 0, 0, 255, 0, 255));
      directed.push_back(make_pair(255, 255, 0, 255, 0, 0));
      directed.push_back(make_pair(0, 0, 255, 0, 0, 0));
      directed.push_back(make_pair(255, 0, 255, 255, 0, 0));
      // red and blue swing together, in both directions
      directed.push_back(make_pair(255, 0, 0, 0, 0, 255));
      directed.push_back(make_pair(0, 0, 255, 255, 0, 0));
      // one-step differences near the bottom of the root
      directed.push_back(make_pair(0, 0, 0, 1, 0, 0));
      directed.push_back(make_pair(0, 0, 0, 0, 1, 0));
      directed.push_back(make_pair(0, 0, 0, 0, 0, 1));
      directed.push_back(make_pair(255, 255, 255, 254, 254, 254));
      // alternating bit patterns across all fields
      directed.push_back(make_pair(8'hAA, 8'h55, 8'hAA, 8'h55, 8'hAA, 8'h55));
      directed.push_back(make_pair(8'h55, 8'hAA, 8'h55, 8'hAA, 8'h55, 8'hAA));

      foreach (directed[i]) begin
         send_request(directed[i]);
         pace_requests();
      end
      directed_reqs = directed.size();

      for (int i = 0; i < RANDOM_REQS; i++) begin
         send_request(random_pair());
         pace_requests();
      end
      @(negedge clock);
      req_tvalid <= 1'b0;

      // drain the pipe; the watchdog catches a missing response
      while (sb.pending() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("sent %0d color pairs (%0d directed), checked %0d distances",
               sb.requests_noted, directed_reqs, sb.responses_checked);
      $display("zero distances seen %0d, largest distance %0d, mismatches %0d",
               sb.zero_distances, sb.max_distance, sb.mismatches);
      if (sb.mismatches == 0 && sb.pending() == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

endmodule
